@@ hw/rtl/mnva_pkg.sv @@
`timescale 1ns / 1ps

package mnva_pkg;

    localparam int VOICES = 8;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);

    localparam int KEYS   = 128;
    localparam int KEY_W  = 7;
    localparam int VEL_W  = 7;

    localparam logic [7:0] STATUS_MASK     = 8'hF0;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

    localparam logic [1:0] FRAME_IDLE   = 2'd0;
    localparam logic [1:0] FRAME_STATUS = 2'd1;
    localparam logic [1:0] FRAME_KEY    = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_NOTE_ON  = 2'd2,
        KIND_OTHER    = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_REL   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

@@ hw/rtl/mnva_ram.sv @@
`timescale 1ns / 1ps

module mnva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/midi_note_voice_allocator.sv @@
`timescale 1ns / 1ps

// channel   signals                              direction
// byte      byte_valid, byte_stall, midi_byte    in
// result    result_valid, result_stall, message_complete, event_kind,
//           note_number, note_velocity, voice_assigned, voice_index,
//           voice_stolen, busy_voices            out
//
// status and key bytes go straight to the output state; a completed message runs the
// release pass and a drain state first, and a note on runs the voice scan before that:
// one shared compare walks the voices for the free or lowest-note voice,
// then the release pass reads the key velocity memory once per voice
// reset clears framing, voice busy bits and the key velocity valid bits at once
// one result beat per byte; the block takes a byte only when idle, and a
// finished result waits in the output register while the next byte is worked on

module midi_note_voice_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] midi_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       message_complete,
    output logic [1:0] event_kind,
    output logic [6:0] note_number,
    output logic [6:0] note_velocity,
    output logic       voice_assigned,
    output logic [2:0] voice_index,
    output logic       voice_stolen,
    output logic [3:0] busy_voices
);

    mnva_pkg::state_t state_reg, state_next;

    logic [1:0]                  frame_pos_reg, frame_pos_next;
    logic [7:0]                  status_reg, status_next;
    logic [mnva_pkg::KEY_W-1:0]  key_hold_reg, key_hold_next;

    logic [mnva_pkg::VIDX_W-1:0] idx_reg, idx_next;
    logic [mnva_pkg::CNT_W-1:0]  busy_count_reg, busy_count_next;
    logic [mnva_pkg::VOICES-1:0] voice_busy_reg, voice_busy_next;
    logic [mnva_pkg::KEY_W-1:0]  voice_note_reg [mnva_pkg::VOICES];

    logic [mnva_pkg::KEY_W-1:0]  min_note_reg, min_note_next;
    logic [mnva_pkg::VIDX_W-1:0] min_idx_reg, min_idx_next;

    logic                        chk_valid_reg, chk_valid_next;
    logic [mnva_pkg::VIDX_W-1:0] chk_idx_reg;
    logic                        chk_busy_reg;

    logic [mnva_pkg::KEYS-1:0]   key_valid_reg;
    logic                        rd_valid_reg;

    // result being built
    logic                        res_complete_reg, res_complete_next;
    mnva_pkg::kind_t             res_kind_reg, res_kind_next;
    logic [mnva_pkg::KEY_W-1:0]  res_note_reg, res_note_next;
    logic [mnva_pkg::VEL_W-1:0]  res_vel_reg, res_vel_next;
    logic                        res_assigned_reg, res_assigned_next;
    logic [mnva_pkg::VIDX_W-1:0] res_idx_reg, res_idx_next;
    logic                        res_stolen_reg, res_stolen_next;

    logic                        out_valid_reg;

    logic                        accept;
    logic                        out_free;
    logic [7:0]                  status_kind;
    logic [mnva_pkg::VEL_W-1:0]  byte_data;
    logic                        ram_we;
    logic [mnva_pkg::VEL_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [mnva_pkg::KEY_W-1:0]  ram_raddr;
    logic [mnva_pkg::VEL_W-1:0]  ram_rdata;
    logic                        idx_last;
    logic [mnva_pkg::KEY_W-1:0]  cur_note;
    logic                        cand_less;
    logic                        assign_now;
    logic [mnva_pkg::VIDX_W-1:0] assign_idx;
    logic                        release_now;

    assign accept      = byte_valid && !byte_stall;
    assign byte_stall  = (state_reg != mnva_pkg::ST_IDLE);
    assign out_free    = !out_valid_reg || !result_stall;
    assign status_kind = status_reg & mnva_pkg::STATUS_MASK;
    assign byte_data   = midi_byte[mnva_pkg::VEL_W-1:0];
    assign idx_last    = (idx_reg == mnva_pkg::VIDX_W'(mnva_pkg::VOICES - 1));
    assign cur_note    = voice_note_reg[idx_reg];
    assign cand_less   = (idx_reg == '0) || (cur_note < min_note_reg);

    // key velocity store, written when the third byte of a note message lands
    assign ram_we    = accept && (frame_pos_reg == mnva_pkg::FRAME_KEY)
                       && ((status_kind == mnva_pkg::STATUS_NOTE_OFF)
                           || (status_kind == mnva_pkg::STATUS_NOTE_ON));
    assign ram_wdata = (status_kind == mnva_pkg::STATUS_NOTE_ON) ? byte_data : '0;
    assign ram_re    = (state_reg == mnva_pkg::ST_REL);
    assign ram_raddr = cur_note;

    mnva_ram #(
        .WIDTH (mnva_pkg::VEL_W),
        .DEPTH (mnva_pkg::KEYS)
    ) u_key_vel (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (key_hold_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // check stage of the release pass: voice is freed when its key has no velocity
    assign release_now = chk_valid_reg && chk_busy_reg
                         && (!rd_valid_reg || (ram_rdata == '0));

    always_comb
    begin
        state_next        = state_reg;
        frame_pos_next    = frame_pos_reg;
        status_next       = status_reg;
        key_hold_next     = key_hold_reg;
        idx_next          = idx_reg;
        min_note_next     = min_note_reg;
        min_idx_next      = min_idx_reg;
        chk_valid_next    = 1'b0;
        res_complete_next = res_complete_reg;
        res_kind_next     = res_kind_reg;
        res_note_next     = res_note_reg;
        res_vel_next      = res_vel_reg;
        res_assigned_next = res_assigned_reg;
        res_idx_next      = res_idx_reg;
        res_stolen_next   = res_stolen_reg;
        assign_now        = 1'b0;
        assign_idx        = idx_reg;

        unique case (state_reg)
            mnva_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_complete_next = 1'b0;
                    res_kind_next     = mnva_pkg::KIND_NONE;
                    res_note_next     = '0;
                    res_vel_next      = '0;
                    res_assigned_next = 1'b0;
                    res_idx_next      = '0;
                    res_stolen_next   = 1'b0;
                    idx_next          = '0;
                    state_next        = mnva_pkg::ST_OUT;
                    priority if (frame_pos_reg == mnva_pkg::FRAME_STATUS)
                    begin
                        key_hold_next  = byte_data;
                        frame_pos_next = mnva_pkg::FRAME_KEY;
                    end
                    else if (frame_pos_reg == mnva_pkg::FRAME_KEY)
                    begin
                        res_complete_next = 1'b1;
                        res_note_next     = key_hold_reg;
                        res_vel_next      = byte_data;
                        frame_pos_next    = mnva_pkg::FRAME_IDLE;
                        status_next       = '0;
                        state_next        = mnva_pkg::ST_REL;
                        priority if (status_kind == mnva_pkg::STATUS_NOTE_OFF)
                        begin
                            res_kind_next = mnva_pkg::KIND_NOTE_OFF;
                        end
                        else if (status_kind == mnva_pkg::STATUS_NOTE_ON)
                        begin
                            res_kind_next = mnva_pkg::KIND_NOTE_ON;
                            state_next    = mnva_pkg::ST_SCAN;
                        end
                        else
                        begin
                            res_kind_next = mnva_pkg::KIND_OTHER;
                        end
                    end
                    else
                    begin
                        frame_pos_next = mnva_pkg::FRAME_IDLE;
                        if (midi_byte != 8'd0)
                        begin
                            status_next    = midi_byte;
                            frame_pos_next = mnva_pkg::FRAME_STATUS;
                        end
                    end
                end
            end

            mnva_pkg::ST_SCAN:
            begin
                if (cand_less)
                begin
                    min_note_next = cur_note;
                    min_idx_next  = idx_reg;
                end
                priority if (!voice_busy_reg[idx_reg])
                begin
                    assign_now      = 1'b1;
                    assign_idx      = idx_reg;
                    res_stolen_next = 1'b0;
                end
                else if (idx_last)
                begin
                    assign_now      = 1'b1;
                    assign_idx      = cand_less ? idx_reg : min_idx_reg;
                    res_stolen_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (assign_now)
                begin
                    res_assigned_next = 1'b1;
                    res_idx_next      = assign_idx;
                    idx_next          = '0;
                    state_next        = mnva_pkg::ST_REL;
                end
            end

            mnva_pkg::ST_REL:
            begin
                chk_valid_next = 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = mnva_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            mnva_pkg::ST_DRAIN:
            begin
                state_next = mnva_pkg::ST_OUT;
            end

            mnva_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = mnva_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mnva_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        voice_busy_next = voice_busy_reg;
        busy_count_next = busy_count_reg;
        if (assign_now)
        begin
            voice_busy_next[assign_idx] = 1'b1;
            if (!res_stolen_next)
            begin
                busy_count_next = busy_count_reg + 1'b1;
            end
        end
        if (release_now)
        begin
            voice_busy_next[chk_idx_reg] = 1'b0;
            busy_count_next = busy_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mnva_pkg::ST_IDLE;
            frame_pos_reg  <= mnva_pkg::FRAME_IDLE;
            status_reg     <= '0;
            idx_reg        <= '0;
            busy_count_reg <= '0;
            voice_busy_reg <= '0;
            chk_valid_reg  <= 1'b0;
            key_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_pos_reg  <= frame_pos_next;
            status_reg     <= status_next;
            idx_reg        <= idx_next;
            busy_count_reg <= busy_count_next;
            voice_busy_reg <= voice_busy_next;
            chk_valid_reg  <= chk_valid_next;
            if (ram_we)
            begin
                key_valid_reg[key_hold_reg] <= 1'b1;
            end
            if ((state_reg == mnva_pkg::ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_hold_reg     <= key_hold_next;
        min_note_reg     <= min_note_next;
        min_idx_reg      <= min_idx_next;
        res_complete_reg <= res_complete_next;
        res_kind_reg     <= res_kind_next;
        res_note_reg     <= res_note_next;
        res_vel_reg      <= res_vel_next;
        res_assigned_reg <= res_assigned_next;
        res_idx_reg      <= res_idx_next;
        res_stolen_reg   <= res_stolen_next;
        if (assign_now)
        begin
            voice_note_reg[assign_idx] <= res_note_reg;
        end
        if (ram_re)
        begin
            chk_idx_reg  <= idx_reg;
            chk_busy_reg <= voice_busy_reg[idx_reg];
            rd_valid_reg <= key_valid_reg[ram_raddr];
        end
        if ((state_reg == mnva_pkg::ST_OUT) && out_free)
        begin
            message_complete <= res_complete_reg;
            event_kind       <= res_kind_reg;
            note_number      <= res_note_reg;
            note_velocity    <= res_vel_reg;
            voice_assigned   <= res_assigned_reg;
            voice_index      <= 3'(res_idx_reg);
            voice_stolen     <= res_stolen_reg;
            busy_voices      <= 4'(busy_count_reg);
        end
    end

    assign result_valid = out_valid_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        busy_count_reg == mnva_pkg::CNT_W'($countones(voice_busy_reg)))
        else $error("busy count out of step with voice busy bits");

    a_beat_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mnva_pkg::ST_OUT))
        else $error("result beat raised outside the output state");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> $past(state_reg == mnva_pkg::ST_REL))
        else $error("release check without a velocity read");

    a_frame_legal: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg != 2'd3)
        else $error("frame position out of range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != mnva_pkg::ST_IDLE))
        else $error("accepted byte did not start work");

endmodule

@@ tb/midi_note_voice_allocator_test.sv @@
`timescale 1ns / 1ps

module midi_note_voice_allocator_test;

    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned RANDOM_BYTES    = 900;
    localparam int unsigned TAIL_CYCLES     = 40;

    typedef struct packed {
        logic                        complete;
        mnva_pkg::kind_t             kind;
        logic [mnva_pkg::KEY_W-1:0]  key;
        logic [mnva_pkg::VEL_W-1:0]  vel;
        logic                        assigned;
        logic [mnva_pkg::VIDX_W-1:0] voice;
        logic                        stolen;
        logic [3:0]                  busy;
    } alloc_result_t;

    typedef struct {
        logic [7:0]  value;
        int unsigned gap;
        bit          drain;
    } tx_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] midi_byte = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       message_complete;
    logic [1:0] event_kind;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic       voice_assigned;
    logic [2:0] voice_index;
    logic       voice_stolen;
    logic [3:0] busy_voices;

    // allocator state as the block should hold it
    logic [1:0]                 frame_pos = mnva_pkg::FRAME_IDLE;
    logic [7:0]                 status_hold = '0;
    logic [mnva_pkg::KEY_W-1:0] key_hold = '0;
    logic [mnva_pkg::VEL_W-1:0] key_vel [mnva_pkg::KEYS] = '{default: '0};
    logic [mnva_pkg::KEY_W-1:0] voice_key [mnva_pkg::VOICES] = '{default: '0};
    logic                       voice_on [mnva_pkg::VOICES] = '{default: 1'b0};

    tx_beat_t      tx_bytes [$];
    alloc_result_t voice_events [$];

    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    bit          calm_tx = 1'b0;
    bit          calm_rx = 1'b0;
    bit          next_valid;
    tx_beat_t    beat;
    alloc_result_t want;

    midi_note_voice_allocator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .midi_byte        (midi_byte),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .message_complete (message_complete),
        .event_kind       (event_kind),
        .note_number      (note_number),
        .note_velocity    (note_velocity),
        .voice_assigned   (voice_assigned),
        .voice_index      (voice_index),
        .voice_stolen     (voice_stolen),
        .busy_voices      (busy_voices)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic track_midi_byte(input logic [7:0] b);
        alloc_result_t r;
        int unsigned pick;
        int unsigned busy;
        bit found;
        r = '0;
        r.kind = mnva_pkg::KIND_NONE;
        case (frame_pos)
            mnva_pkg::FRAME_STATUS:
            begin
                key_hold = b[6:0];
                frame_pos = mnva_pkg::FRAME_KEY;
            end
            mnva_pkg::FRAME_KEY:
            begin
                r.complete = 1'b1;
                r.key = key_hold;
                r.vel = b[6:0];
                if ((status_hold & mnva_pkg::STATUS_MASK) == mnva_pkg::STATUS_NOTE_OFF)
                begin
                    r.kind = mnva_pkg::KIND_NOTE_OFF;
                    key_vel[key_hold] = '0;
                end
                else if ((status_hold & mnva_pkg::STATUS_MASK) == mnva_pkg::STATUS_NOTE_ON)
                begin
                    r.kind = mnva_pkg::KIND_NOTE_ON;
                    key_vel[key_hold] = b[6:0];
                    found = 1'b0;
                    pick = 0;
                    for (int i = 0; i < mnva_pkg::VOICES; i++)
                        if (!found && !voice_on[i])
                        begin
                            pick = i;
                            found = 1'b1;
                        end
                    // all busy: steal lowest key, first index wins ties
                    if (!found)
                    begin
                        for (int i = 1; i < mnva_pkg::VOICES; i++)
                            if (voice_key[i] < voice_key[pick])
                                pick = i;
                        r.stolen = 1'b1;
                    end
                    voice_key[pick] = key_hold;
                    voice_on[pick] = 1'b1;
                    r.assigned = 1'b1;
                    r.voice = pick[mnva_pkg::VIDX_W-1:0];
                end
                else
                    r.kind = mnva_pkg::KIND_OTHER;
                for (int i = 0; i < mnva_pkg::VOICES; i++)
                    if (voice_on[i] && key_vel[voice_key[i]] == '0)
                        voice_on[i] = 1'b0;
                frame_pos = mnva_pkg::FRAME_IDLE;
                status_hold = '0;
                key_hold = '0;
            end
            default:
            begin
                frame_pos = mnva_pkg::FRAME_IDLE;
                if (b != 8'h00)
                begin
                    status_hold = b;
                    frame_pos = mnva_pkg::FRAME_STATUS;
                end
            end
        endcase
        busy = 0;
        for (int i = 0; i < mnva_pkg::VOICES; i++)
            if (voice_on[i])
                busy++;
        r.busy = busy[3:0];
        voice_events.push_back(r);
    endtask

    function automatic void check_field(string field, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function automatic void add_byte(logic [7:0] value, bit drain);
        tx_beat_t t;
        // alternate stretches of back-to-back beats with gappy ones
        if (tx_bytes.size() % 50 == 0)
            calm_tx = ($urandom_range(0, 3) == 0);
        t.value = value;
        t.gap = calm_tx ? 0 : $urandom_range(0, 18);
        t.drain = drain;
        tx_bytes.push_back(t);
    endfunction

    function automatic void add_msg(logic [7:0] status, logic [7:0] key,
                                    logic [7:0] vel, bit drain);
        add_byte(status, drain);
        add_byte(key, 1'b0);
        add_byte(vel, 1'b0);
    endfunction

    // data bytes sometimes carry a stray top bit, the block must mask it
    function automatic logic [7:0] data_byte(logic [6:0] v);
        return {($urandom_range(0, 4) == 0), v};
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            gap_left = tx_bytes.size() ? tx_bytes[0].gap : 0;
        end
        else
        begin
            next_valid = byte_valid;
            if (byte_valid && !byte_stall)
            begin
                track_midi_byte(midi_byte);
                next_valid = 1'b0;
                gap_left = tx_bytes.size() ? tx_bytes[0].gap : 0;
            end
            if (!next_valid && tx_bytes.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (!(tx_bytes[0].drain && voice_events.size() != 0))
                begin
                    beat = tx_bytes.pop_front();
                    midi_byte <= beat.value;
                    next_valid = 1'b1;
                end
            end
            byte_valid <= next_valid;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (voice_events.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, kind %0d note %0d",
                             $time, event_kind, note_number);
                    mismatches++;
                end
                else
                begin
                    want = voice_events.pop_front();
                    check_field("message_complete", want.complete, message_complete);
                    check_field("event_kind", want.kind, event_kind);
                    check_field("note_number", want.key, note_number);
                    check_field("note_velocity", want.vel, note_velocity);
                    check_field("voice_assigned", want.assigned, voice_assigned);
                    check_field("voice_index", want.voice, voice_index);
                    check_field("voice_stolen", want.stolen, voice_stolen);
                    check_field("busy_voices", want.busy, busy_voices);
                end
                results_seen++;
                if (results_seen % 64 == 0)
                    calm_rx = ($urandom_range(0, 2) == 0);
                hold_left = calm_rx ? 0 : $urandom_range(0, 18);
            end
            else if (result_valid && hold_left != 0)
                hold_left--;
            result_stall <= (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("FAIL midi_note_voice_allocator");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned roll;
        int unsigned n;
        logic [6:0] key;
        logic [6:0] vel;
        logic [7:0] status;
        bit drain;

        // directed: zero byte outside a frame, key and velocity extremes,
        // masked data bytes, note off, zero velocity note on, other statuses
        add_byte(8'h00, 1'b0);
        add_msg(mnva_pkg::STATUS_NOTE_ON, 8'h00, 8'h7f, 1'b0);
        add_msg(mnva_pkg::STATUS_NOTE_ON | 8'h0f, 8'hff, 8'h81, 1'b0);
        add_msg(mnva_pkg::STATUS_NOTE_OFF, 8'h00, 8'h40, 1'b0);
        add_msg(mnva_pkg::STATUS_NOTE_ON, 8'h3c, 8'h00, 1'b0);
        add_msg(8'hb0, 8'h07, 8'h64, 1'b0);
        add_msg(8'hff, 8'h80, 8'hff, 1'b0);
        add_msg(8'h01, 8'h00, 8'h00, 1'b0);
        add_msg(mnva_pkg::STATUS_NOTE_OFF | 8'h05, 8'hff, 8'h00, 1'b0);

        // random: mostly well formed note traffic on a narrow key range so
        // voices fill up and get stolen, with some stray bytes in between
        drain = 1'b1;
        while (tx_bytes.size() < RANDOM_BYTES + 25)
        begin
            roll = $urandom_range(0, 99);
            key = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(40, 55))
                                              : 7'($urandom_range(0, 127));
            vel = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
            if (roll < 55)
                add_msg(mnva_pkg::STATUS_NOTE_ON | 8'($urandom_range(0, 15)),
                        data_byte(key), data_byte(vel), drain);
            else if (roll < 85)
                add_msg(mnva_pkg::STATUS_NOTE_OFF | 8'($urandom_range(0, 15)),
                        data_byte(key), data_byte(vel), drain);
            else if (roll < 92)
            begin
                do
                    status = 8'($urandom_range(1, 255));
                while ((status & mnva_pkg::STATUS_MASK) == mnva_pkg::STATUS_NOTE_OFF ||
                       (status & mnva_pkg::STATUS_MASK) == mnva_pkg::STATUS_NOTE_ON);
                add_msg(status, data_byte(key), data_byte(vel), drain);
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    add_byte(($urandom_range(0, 3) == 0) ? 8'h00
                                                         : 8'($urandom_range(0, 255)),
                             drain);
            end
            drain = ($urandom_range(0, 99) == 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || byte_valid)
            @(posedge clk);
        while (voice_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS midi_note_voice_allocator");
        else
            $display("FAIL midi_note_voice_allocator");
        $finish;
    end

endmodule
